@@ rtl/core/box_blur_3x3_edge_aware_assert.svh @@
// ============================================================================
// Assertion macros for the box blur block
// Concurrent assertion wrappers that compile away when ASSERT_OFF is set.
// ============================================================================
`ifndef BOX_BLUR_3X3_EDGE_AWARE_ASSERT_SVH
`define BOX_BLUR_3X3_EDGE_AWARE_ASSERT_SVH
`ifndef ASSERT_OFF
`define BBEA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BBEA_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define BBEA_ASSERT(label, clk, rst_n, prop, msg)
`define BBEA_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

@@ rtl/core/bbea_pkg.sv @@
// ============================================================================
// Box blur package
// Types, codes and constants shared by the box blur modules.
// ============================================================================
package bbea_pkg;

    localparam int CW          = 11;
    localparam int RW          = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int TAPS        = 9;
    localparam int SUM_W       = 12;
    localparam int CNT_W       = 4;
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic [1:0] TAP_LEFT  = 2'd0;
    localparam logic [1:0] TAP_MID   = 2'd1;
    localparam logic [1:0] TAP_RIGHT = 2'd2;

    typedef enum logic {
        ACT_PIXEL = 1'b0,
        ACT_DRAIN = 1'b1
    } action_t;

    typedef enum logic {
        CMD_PIXEL,
        CMD_DRAIN
    } cmd_kind_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_LOAD,
        BK_SUM,
        BK_MUL
    } back_state_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef logic [TAPS-1:0] tap_mask_t;

    typedef struct packed {
        cmd_kind_t       kind;
        logic [CW-1:0]   col;
        pixel_t          pix;
        logic            emit_a;
        tap_mask_t       mask_a;
        logic            emit_b;
        tap_mask_t       mask_b;
        logic            frame_end;
    } cmd_t;

    // Rounded-up reciprocal of the tap count, exact for every 3x3 sum of bytes.
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] r;
        case (cnt)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8192;
            4'd9:    r = 17'd7282;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/bbea_ram.sv @@
// ============================================================================
// Generic line RAM
// One write port and one read port with registered read data.
// ============================================================================
module bbea_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/bbea_front.sv @@
// ============================================================================
// Box blur front end
// Holds the frame configuration and scan position, classifies each item and
// issues commands with tap masks to the back end.
// ============================================================================
module bbea_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bbea_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bbea_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [23:0]                         s_tdata,
    input  logic                                s_tuser,
    input  logic                                q_full,
    output logic                                push_valid,
    output bbea_pkg::cmd_t                      push_cmd
);

    localparam int CW = bbea_pkg::CW;
    localparam int RW = bbea_pkg::RW;
    localparam logic [CW-1:0] WIDTH_RESET = CW'((MAX_WIDTH < 640) ? MAX_WIDTH : 640);
    localparam logic [RW-1:0] HEIGHT_RESET = RW'(480);

    logic [CW-1:0] width_reg, width_next;
    logic [RW-1:0] height_reg, height_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] drain_reg, drain_next;

    logic [CW-1:0] cfg_width;
    logic [RW-1:0] cfg_height;
    logic          s_accept;
    logic          is_drain;
    logic          row_ge1;
    logic          row_ge2;
    logic          two_rows;
    logic          col_last;
    logic          pix_ok;
    logic          drain_ok;
    logic [CW-1:0] drain_col;
    logic          drain_last;
    bbea_pkg::tap_mask_t mask9;
    bbea_pkg::tap_mask_t mask6;
    bbea_pkg::tap_mask_t mask_drain;
    bbea_pkg::pixel_t    in_pix;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full && !cfg_valid;
    assign s_accept  = s_tvalid && s_tready;
    assign is_drain  = (s_tuser == bbea_pkg::ACT_DRAIN);

    assign in_pix.red   = s_tdata[7:0];
    assign in_pix.green = s_tdata[15:8];
    assign in_pix.blue  = s_tdata[23:16];

    always_comb begin
        cfg_width = cfg_data[CW-1:0];
        if (cfg_width == '0) begin
            cfg_width = CW'(1);
        end else if (32'(cfg_width) > MAX_WIDTH) begin
            cfg_width = CW'(MAX_WIDTH);
        end
        cfg_height = cfg_data[RW-1:0];
        if (cfg_height == '0) begin
            cfg_height = RW'(1);
        end
    end

    assign row_ge1    = (row_reg != '0);
    assign row_ge2    = (row_reg > RW'(1));
    assign two_rows   = (height_reg > RW'(1));
    assign col_last   = (col_reg == (width_reg - CW'(1)));
    assign pix_ok     = (row_reg < height_reg) && (col_reg < width_reg);
    assign drain_ok   = (row_reg >= height_reg);
    assign drain_col  = (drain_reg >= width_reg) ? (width_reg - CW'(1)) : drain_reg;
    assign drain_last = (drain_col == (width_reg - CW'(1)));

    // Window taps are numbered column by column, oldest column first, top row first.
    always_comb begin
        for (int i = 0; i < bbea_pkg::TAPS; i++) begin
            mask9[i] = (((i % 3) != 0) || row_ge2) && ((i >= 3) || (col_reg >= CW'(2)));
            mask6[i] = (i >= 3) && (((i % 3) != 0) || row_ge2) &&
                       ((i >= 6) || (col_reg != '0));
        end
        mask_drain    = '0;
        mask_drain[0] = (drain_col != '0) && two_rows;
        mask_drain[1] = (drain_col != '0);
        mask_drain[3] = two_rows;
        mask_drain[4] = 1'b1;
        mask_drain[6] = !drain_last && two_rows;
        mask_drain[7] = !drain_last;
    end

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        drain_next  = drain_reg;
        push_valid  = 1'b0;
        push_cmd    = '0;
        if (cfg_valid) begin
            case (cfg_index)
                bbea_pkg::REG_FRAME_WIDTH:  width_next  = cfg_width;
                bbea_pkg::REG_FRAME_HEIGHT: height_next = cfg_height;
                default: ;
            endcase
            row_next   = '0;
            col_next   = '0;
            drain_next = '0;
        end else if (s_accept) begin
            if (!is_drain) begin
                if (pix_ok) begin
                    push_valid      = 1'b1;
                    push_cmd.kind   = bbea_pkg::CMD_PIXEL;
                    push_cmd.col    = col_reg;
                    push_cmd.pix    = in_pix;
                    push_cmd.emit_a = row_ge1 && (col_reg != '0);
                    push_cmd.mask_a = mask9;
                    push_cmd.emit_b = row_ge1 && col_last;
                    push_cmd.mask_b = mask6;
                    if (col_last) begin
                        col_next   = '0;
                        row_next   = row_reg + RW'(1);
                        drain_next = '0;
                    end else begin
                        col_next = col_reg + CW'(1);
                    end
                end
            end else if (drain_ok) begin
                push_valid         = 1'b1;
                push_cmd.kind      = bbea_pkg::CMD_DRAIN;
                push_cmd.col       = drain_col;
                push_cmd.emit_a    = 1'b1;
                push_cmd.mask_a    = mask_drain;
                push_cmd.frame_end = drain_last;
                if (drain_last) begin
                    row_next   = '0;
                    col_next   = '0;
                    drain_next = '0;
                end else begin
                    drain_next = drain_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            row_reg    <= '0;
            col_reg    <= '0;
            drain_reg  <= '0;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            drain_reg  <= drain_next;
        end
    end

endmodule

@@ rtl/core/bbea_cmd_fifo.sv @@
// ============================================================================
// Box blur command queue
// Short FIFO that decouples the front end from the back end.
// ============================================================================
module bbea_cmd_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    input  bbea_pkg::cmd_t  push_cmd,
    output logic            full,
    output logic            pop_valid,
    input  logic            pop_ready,
    output bbea_pkg::cmd_t  pop_cmd
);

    localparam int DEPTH = bbea_pkg::QUEUE_DEPTH;
    localparam int PW    = bbea_pkg::QPTR_W;

    bbea_pkg::cmd_t entry_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PW:0]    count_reg, count_next;
    logic           do_push;
    logic           do_pop;

    assign full      = (count_reg == (PW + 1)'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + (PW + 1)'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - (PW + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/core/bbea_back.sv @@
// ============================================================================
// Box blur back end
// Owns the two line buffers and the 3x3 window, forms masked sums, divides
// by the tap count and holds each result in an output register.
// ============================================================================
`include "box_blur_3x3_edge_aware_assert.svh"

module bbea_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    input  bbea_pkg::cmd_t  q_cmd,
    output logic            q_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [23:0]     m_tdata,
    output logic            m_tlast
);

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int CW    = bbea_pkg::CW;
    localparam int SUM_W = bbea_pkg::SUM_W;
    localparam int CNT_W = bbea_pkg::CNT_W;
    localparam int PRODW = bbea_pkg::SUM_W + bbea_pkg::RECIP_W;
    localparam int PIX_W = $bits(bbea_pkg::pixel_t);

    bbea_pkg::back_state_t state_reg, state_next;
    bbea_pkg::cmd_t        cmd_reg;
    logic [1:0]            tap_reg, tap_next;
    logic                  second_reg, second_next;
    bbea_pkg::pixel_t      win_reg [bbea_pkg::TAPS];
    bbea_pkg::pixel_t      win_next [bbea_pkg::TAPS];
    logic [SUM_W-1:0]      sum_r_reg, sum_g_reg, sum_b_reg;
    logic [SUM_W-1:0]      sum_r_next, sum_g_next, sum_b_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  out_valid_reg, out_valid_next;
    bbea_pkg::pixel_t      out_pix_reg;
    logic                  out_last_reg;

    logic                  ram_re;
    logic                  ram_we;
    logic [AW-1:0]         ram_raddr;
    logic [AW-1:0]         ram_waddr;
    logic [CW-1:0]         rd_col;
    logic [PIX_W-1:0]      older_rd;
    logic [PIX_W-1:0]      newer_rd;
    logic [PIX_W-1:0]      older_wd;
    logic [PIX_W-1:0]      newer_wd;
    logic                  load_done;
    logic                  out_free;
    logic                  out_load;
    bbea_pkg::tap_mask_t   sel_mask;
    logic [bbea_pkg::RECIP_W-1:0] rcp;
    logic [PRODW-1:0]      prod_r, prod_g, prod_b;

    bbea_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (older_wd),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (older_rd)
    );

    bbea_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (newer_wd),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (newer_rd)
    );

    assign load_done = (cmd_reg.kind == bbea_pkg::CMD_PIXEL) || (tap_reg == bbea_pkg::TAP_RIGHT);
    assign out_free  = !out_valid_reg || m_tready;

    // Next state.
    always_comb begin
        state_next  = state_reg;
        tap_next    = tap_reg;
        second_next = second_reg;
        case (state_reg)
            bbea_pkg::BK_IDLE: begin
                if (q_valid) begin
                    state_next = bbea_pkg::BK_READ;
                    tap_next   = bbea_pkg::TAP_LEFT;
                end
            end
            bbea_pkg::BK_READ: begin
                state_next = bbea_pkg::BK_LOAD;
            end
            bbea_pkg::BK_LOAD: begin
                if (load_done) begin
                    if (cmd_reg.emit_a || cmd_reg.emit_b) begin
                        state_next  = bbea_pkg::BK_SUM;
                        second_next = !cmd_reg.emit_a;
                    end else begin
                        state_next = bbea_pkg::BK_IDLE;
                    end
                end else begin
                    state_next = bbea_pkg::BK_READ;
                    tap_next   = tap_reg + 2'd1;
                end
            end
            bbea_pkg::BK_SUM: begin
                state_next = bbea_pkg::BK_MUL;
            end
            bbea_pkg::BK_MUL: begin
                if (out_free) begin
                    if (!second_reg && cmd_reg.emit_b) begin
                        state_next  = bbea_pkg::BK_SUM;
                        second_next = 1'b1;
                    end else begin
                        state_next = bbea_pkg::BK_IDLE;
                    end
                end
            end
            default: begin
                state_next = bbea_pkg::BK_IDLE;
            end
        endcase
    end

    // Outputs of the state machine.
    always_comb begin
        q_pop    = (state_reg == bbea_pkg::BK_IDLE) && q_valid;
        ram_re   = (state_reg == bbea_pkg::BK_READ);
        ram_we   = (state_reg == bbea_pkg::BK_LOAD) && (cmd_reg.kind == bbea_pkg::CMD_PIXEL);
        out_load = (state_reg == bbea_pkg::BK_MUL) && out_free;
        rd_col   = cmd_reg.col;
        if (cmd_reg.kind == bbea_pkg::CMD_DRAIN) begin
            case (tap_reg)
                bbea_pkg::TAP_LEFT: begin
                    if (cmd_reg.mask_a[1]) begin
                        rd_col = cmd_reg.col - CW'(1);
                    end
                end
                bbea_pkg::TAP_RIGHT: begin
                    if (cmd_reg.mask_a[7]) begin
                        rd_col = cmd_reg.col + CW'(1);
                    end
                end
                default: ;
            endcase
        end
        ram_raddr = AW'(rd_col);
        ram_waddr = AW'(cmd_reg.col);
        older_wd  = newer_rd;
        newer_wd  = cmd_reg.pix;
    end

    // Window shift, masked sums and the reciprocal divide.
    always_comb begin
        for (int i = 0; i < bbea_pkg::TAPS; i++) begin
            win_next[i] = win_reg[i];
        end
        if (state_reg == bbea_pkg::BK_LOAD) begin
            for (int i = 0; i < 6; i++) begin
                win_next[i] = win_reg[i + 3];
            end
            win_next[6] = older_rd;
            win_next[7] = newer_rd;
            win_next[8] = (cmd_reg.kind == bbea_pkg::CMD_PIXEL) ? cmd_reg.pix : '0;
        end

        sel_mask   = second_reg ? cmd_reg.mask_b : cmd_reg.mask_a;
        sum_r_next = '0;
        sum_g_next = '0;
        sum_b_next = '0;
        cnt_next   = '0;
        for (int i = 0; i < bbea_pkg::TAPS; i++) begin
            if (sel_mask[i]) begin
                sum_r_next = sum_r_next + SUM_W'(win_reg[i].red);
                sum_g_next = sum_g_next + SUM_W'(win_reg[i].green);
                sum_b_next = sum_b_next + SUM_W'(win_reg[i].blue);
                cnt_next   = cnt_next + CNT_W'(1);
            end
        end

        rcp    = bbea_pkg::recip(cnt_reg);
        prod_r = PRODW'(sum_r_reg) * PRODW'(rcp);
        prod_g = PRODW'(sum_g_reg) * PRODW'(rcp);
        prod_b = PRODW'(sum_b_reg) * PRODW'(rcp);

        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg <= q_cmd;
        end
        for (int i = 0; i < bbea_pkg::TAPS; i++) begin
            win_reg[i] <= win_next[i];
        end
        if (state_reg == bbea_pkg::BK_SUM) begin
            sum_r_reg <= sum_r_next;
            sum_g_reg <= sum_g_next;
            sum_b_reg <= sum_b_next;
            cnt_reg   <= cnt_next;
        end
        if (out_load) begin
            out_pix_reg.red   <= prod_r[bbea_pkg::RECIP_SHIFT +: 8];
            out_pix_reg.green <= prod_g[bbea_pkg::RECIP_SHIFT +: 8];
            out_pix_reg.blue  <= prod_b[bbea_pkg::RECIP_SHIFT +: 8];
            out_last_reg      <= cmd_reg.frame_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bbea_pkg::BK_IDLE;
            tap_reg       <= bbea_pkg::TAP_LEFT;
            second_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            tap_reg       <= tap_next;
            second_reg    <= second_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_pix_reg.blue, out_pix_reg.green, out_pix_reg.red};
    assign m_tlast  = out_last_reg;

    `BBEA_ASSERT(a_load_after_read, aclk, aresetn, state_reg == bbea_pkg::BK_LOAD |-> $past(state_reg) == bbea_pkg::BK_READ, "line buffer data used without a read")
    `BBEA_ASSERT_NEVER(a_count_range, aclk, aresetn, state_reg == bbea_pkg::BK_MUL && (cnt_reg == '0 || cnt_reg > 4'd9), "tap count out of range")
    `BBEA_ASSERT(a_second_result, aclk, aresetn, second_reg && (state_reg == bbea_pkg::BK_SUM || state_reg == bbea_pkg::BK_MUL) |-> cmd_reg.emit_b, "second average without a row-end result")

endmodule

@@ rtl/core/box_blur_3x3_edge_aware.sv @@
// ============================================================================
// Edge-aware 3x3 box blur
// Streaming RGB box blur over a raster frame with border-aware averaging
// and a drain sequence that emits the final row.
// ============================================================================
// Channel  Dir  Handshake           Payload
// cfg      in   cfg_valid/ready     cfg_index (0 frame_width, 1 frame_height), cfg_data
// s_       in   s_tvalid/tready     s_tdata red, green, blue; s_tuser action
// m_       out  m_tvalid/tready     m_tdata red, green, blue; m_tlast frame_end
//
// A pixel is read and loaded, then summed and multiplied once per result;
// a drain item loads three columns for one result. The single read port of
// each line buffer and the shared averaging unit set this order. Reset is
// synchronous on aresetn and does not clear the line buffers. A two-entry
// command queue and the output register let each side stall on its own.
// ============================================================================
module box_blur_3x3_edge_aware #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bbea_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bbea_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [23:0]                        s_tdata,   // in_red, in_green, in_blue
    input  logic                               s_tuser,   // action
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [23:0]                        m_tdata,   // out_red, out_green, out_blue
    output logic                               m_tlast
);

    logic           q_full;
    logic           push_valid;
    bbea_pkg::cmd_t push_cmd;
    logic           q_valid;
    logic           q_pop;
    bbea_pkg::cmd_t q_cmd;

    bbea_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .q_full     (q_full),
        .push_valid (push_valid),
        .push_cmd   (push_cmd)
    );

    bbea_cmd_fifo u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop_valid  (q_valid),
        .pop_ready  (q_pop),
        .pop_cmd    (q_cmd)
    );

    bbea_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
